>>> hw/rtl/uri_percent_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// uri_percent_decoder_unit assertion macros
// Shorthands for clocked implication checks used by the decoder top level.
// ----------------------------------------------------------------------------
`ifndef URI_PERCENT_DECODER_UNIT_ASSERT_SVH
`define URI_PERCENT_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock and quiet while reset is high
`define URID_ASSERT_HOLD(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock and quiet while reset is high
`define URID_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/urid_pkg.sv
// ----------------------------------------------------------------------------
// urid_pkg
// Shared types, constants and helpers of the URI percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package urid_pkg;

   localparam logic [7:0]  PCT_CHAR    = 8'h25;
   localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;
   localparam logic [15:0] CAP_RESET   = 16'hFFFF;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        done_res;
      logic [15:0] consumed_count;
      logic [15:0] written_count;
   } result_type;

   // all results caused by one request, oldest in rec[0]
   typedef struct packed {
      logic [1:0]            nres;
      result_type [2:0]      rec;
   } bundle_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/urid_front.sv
// ----------------------------------------------------------------------------
// urid_front
// Takes request bytes, tracks held percent sequences and the counters, and
// builds the bundle of results each request causes.
// ----------------------------------------------------------------------------
`default_nettype none

module urid_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic                 q_full,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 final_byte,
   input  wire logic [15:0]          capacity,
   output urid_pkg::bundle_type      bundle,
   output logic                      bundle_push
);

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_PCT   = 2'd1;
   localparam logic [1:0] PEND_DIGIT = 2'd2;

   logic [1:0]  pend_ff, pend_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [15:0] written_ff, written_in;
   logic [15:0] consumed_ff, consumed_in;

   logic        accept;
   logic [4:0]  hex_b;
   logic [4:0]  hex_p;
   logic [15:0] diff;
   logic [1:0]  room;
   logic [7:0]  wbyte [3];
   logic [1:0]  wused [3];
   logic [1:0]  nwant;
   logic [1:0]  nok;
   logic [1:0]  m;
   logic        do_fresh;
   logic [3:0]  cum [3];
   logic [16:0] csum_w [3];
   logic [15:0] csum [3];

   assign accept = push && !q_full;
   assign hex_b  = urid_pkg::hex_decode(in_byte);
   assign hex_p  = urid_pkg::hex_decode(pbyte_ff);

   // free output slots this string, clamped to three
   always_comb begin
      diff = capacity - written_ff;
      if (capacity <= written_ff) begin
         room = 2'd0;
      end else if (diff >= 16'd3) begin
         room = 2'd3;
      end else begin
         room = diff[1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         wbyte[j] = 8'd0;
         wused[j] = 2'd0;
      end
      nwant    = 2'd0;
      m        = 2'd0;
      do_fresh = 1'b0;
      pend_in  = PEND_NONE;
      pbyte_in = pbyte_ff;
      case (pend_ff)
         PEND_PCT: begin
            if (hex_b[4] && !final_byte) begin
               pend_in  = PEND_DIGIT;
               pbyte_in = in_byte;
            end else begin
               wbyte[0] = urid_pkg::PCT_CHAR;
               wused[0] = 2'd1;
               m        = 2'd1;
               do_fresh = 1'b1;
            end
         end
         PEND_DIGIT: begin
            if (hex_b[4]) begin
               wbyte[0] = {hex_p[3:0], hex_b[3:0]};
               wused[0] = 2'd3;
               nwant    = 2'd1;
            end else begin
               wbyte[0] = urid_pkg::PCT_CHAR;
               wused[0] = 2'd1;
               wbyte[1] = pbyte_ff;
               wused[1] = 2'd1;
               m        = 2'd2;
               do_fresh = 1'b1;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase
      if (do_fresh) begin
         if (in_byte == urid_pkg::PCT_CHAR && !final_byte && room > m) begin
            pend_in  = PEND_PCT;
            pbyte_in = in_byte;
            nwant    = m;
         end else begin
            wbyte[m] = in_byte;
            wused[m] = 2'd1;
            nwant    = m + 2'd1;
         end
      end
   end

   // writes succeed as a prefix until capacity runs out
   assign nok = (nwant < room) ? nwant : room;

   always_comb begin
      cum[0] = {2'b00, wused[0]};
      cum[1] = cum[0] + {2'b00, wused[1]};
      cum[2] = cum[1] + {2'b00, wused[2]};
      for (int j = 0; j < 3; j++) begin
         csum_w[j] = {1'b0, consumed_ff} + {13'd0, cum[j]};
         csum[j]   = csum_w[j][16] ? urid_pkg::COUNT_LIMIT : csum_w[j][15:0];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         bundle.rec[j].out_byte       = wbyte[j];
         bundle.rec[j].byte_valid     = 1'b1;
         bundle.rec[j].done_res       = final_byte && (2'(j) == nok - 2'd1);
         bundle.rec[j].consumed_count = csum[j];
         bundle.rec[j].written_count  = written_ff + 16'(j + 1);
      end
      bundle.nres = nok;
      // string ends with nothing written: bare done result
      if (final_byte && nok == 2'd0) begin
         bundle.nres                  = 2'd1;
         bundle.rec[0].out_byte       = 8'd0;
         bundle.rec[0].byte_valid     = 1'b0;
         bundle.rec[0].done_res       = 1'b1;
         bundle.rec[0].consumed_count = consumed_ff;
         bundle.rec[0].written_count  = written_ff;
      end
   end

   assign bundle_push = accept && (bundle.nres != 2'd0);

   always_comb begin
      written_in  = written_ff + {14'd0, nok};
      consumed_in = (nok == 2'd0) ? consumed_ff : csum[nok - 2'd1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= PEND_NONE;
         written_ff  <= 16'd0;
         consumed_ff <= 16'd0;
      end else if (accept) begin
         if (final_byte) begin
            pend_ff     <= PEND_NONE;
            written_ff  <= 16'd0;
            consumed_ff <= 16'd0;
         end else begin
            pend_ff     <= pend_in;
            written_ff  <= written_in;
            consumed_ff <= consumed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pbyte_ff <= pbyte_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/urid_fifo.sv
// ----------------------------------------------------------------------------
// urid_fifo
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module urid_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire urid_pkg::bundle_type wr_data,
   input  wire logic                 rd_en,
   output urid_pkg::bundle_type      rd_data,
   output logic                      q_full,
   output logic                      q_empty
);

   urid_pkg::bundle_type mem_ff [urid_pkg::FIFO_DEPTH];

   logic [urid_pkg::FIFO_PTR_W-1:0] wptr_ff, wptr_in;
   logic [urid_pkg::FIFO_PTR_W-1:0] rptr_ff, rptr_in;
   logic [urid_pkg::FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            do_wr;
   logic                            do_rd;

   assign q_full  = (cnt_ff == urid_pkg::FIFO_CNT_W'(urid_pkg::FIFO_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/urid_back.sv
// ----------------------------------------------------------------------------
// urid_back
// Walks the queue head bundle one result at a time onto the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module urid_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire urid_pkg::bundle_type head,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   input  wire logic                 pop,
   output logic                      empty,
   output urid_pkg::result_type      result
);

   logic [1:0] idx_ff, idx_in;
   logic       take;
   logic       last_of_bundle;

   assign empty          = q_empty;
   assign result         = head.rec[idx_ff];
   assign take           = pop && !q_empty;
   assign last_of_bundle = (idx_ff == head.nres - 2'd1);
   assign q_pop          = take && last_of_bundle;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last_of_bundle ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/uri_percent_decoder_unit.sv
// ----------------------------------------------------------------------------
// uri_percent_decoder_unit
// Streaming URI percent decoder: one encoded byte per request.
// ----------------------------------------------------------------------------
// Usage: requests carry one raw byte and a final flag; a request is taken
// when push is high and full is low. Results leave through empty/pop: the
// oldest result sits on the rsp_ ports while empty is low and is taken when
// pop is high. A request yields zero to three results; the last result of a
// string has done_res set and carries the string's final counts.
// A request's results are registered in the queue and reach rsp_ once
// older results are popped. Throughput: one request per cycle while full
// is low and each request gives at most one result; requests that flush
// held bytes give up to three results, which leave one per pop. A four-bundle
// queue sits between the decode front and the response back, so requests
// keep flowing until it fills, then full rises while the receiver stalls.
// csr_wr_en/csr_wr_data write the output capacity; write it only when idle.
// Reset sets capacity to 65535, clears counters and held bytes and empties
// the queue; no initialization sequence follows.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_final_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_done_res,
   output logic [15:0]      rsp_consumed_count,
   output logic [15:0]      rsp_written_count,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [15:0]          capacity_ff;
   urid_pkg::bundle_type bundle;
   logic                 bundle_push;
   urid_pkg::bundle_type head;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;
   urid_pkg::result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= urid_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   urid_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .q_full      (q_full),
      .in_byte     (req_in_byte),
      .final_byte  (req_final_byte),
      .capacity    (capacity_ff),
      .bundle      (bundle),
      .bundle_push (bundle_push)
   );

   urid_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_push),
      .wr_data (bundle),
      .rd_en   (q_pop),
      .rd_data (head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   urid_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .result  (result)
   );

   assign full               = q_full;
   assign rsp_out_byte       = result.out_byte;
   assign rsp_byte_valid     = result.byte_valid;
   assign rsp_done_res       = result.done_res;
   assign rsp_consumed_count = result.consumed_count;
   assign rsp_written_count  = result.written_count;

`include "uri_percent_decoder_unit_assert.svh"

   `URID_ASSERT_HOLD(a_bare_is_done, !empty && !rsp_byte_valid, rsp_done_res, "done missing")
   `URID_ASSERT_HOLD(a_head_nonzero, !empty, head.nres != 2'd0, "empty bundle queued")
   `URID_ASSERT_HOLD(a_written_nonzero, !empty && rsp_byte_valid, |rsp_written_count, "zero count")
   `URID_ASSERT_NEXT(a_full_holds, full && !q_pop, full, "full dropped without a pop")

endmodule

`default_nettype wire
